### hdl/weighted_nll_loss_accumulator_macros.svh
// assertion macros shared by the loss accumulator rtl
`ifndef WEIGHTED_NLL_LOSS_ACCUMULATOR_MACROS_SVH
`define WEIGHTED_NLL_LOSS_ACCUMULATOR_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define WNLL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define WNLL_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define WNLL_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define WNLL_ASSERT_NXT(label, clk, rst, ante, cons, msg)

`endif

`endif

### hdl/wnll_pkg.sv
// types, constants and helpers for the weighted nll loss accumulator
package wnll_pkg;

   localparam int NUM_CLASSES = 256;
   localparam int CLS_AW      = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

   localparam int LOSS_W = 48;
   localparam int WSUM_W = 47;
   localparam int WT_W   = 32;

   localparam logic signed [WT_W-1:0] ONE_Q16 = 32'sh0001_0000;

   localparam logic signed [LOSS_W-1:0] MAX48 = {1'b0, {(LOSS_W-1){1'b1}}};
   localparam logic signed [LOSS_W-1:0] MIN48 = {1'b1, {(LOSS_W-1){1'b0}}};

   // divider sizes: |loss| << 16 over |weight sum|
   localparam int DIV_NUM_W = 64;
   localparam int DIV_DEN_W = 48;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

   // register indexes
   localparam logic [1:0] CSR_IGNORE_CLASS = 2'd0;
   localparam logic [1:0] CSR_SIZE_AVERAGE = 2'd1;
   localparam logic [1:0] CSR_REDUCE_MODE  = 2'd2;
   localparam logic [1:0] CSR_USE_WEIGHTS  = 2'd3;

   // item kinds
   localparam logic KIND_WEIGHT = 1'b0;
   localparam logic KIND_PIXEL  = 1'b1;

   typedef struct packed {
      logic               kind;
      logic signed [15:0] class_index;
      logic signed [31:0] value;
      logic               last_pixel;
   } req_word_type;

   typedef struct packed {
      logic signed [LOSS_W-1:0] loss;
      logic [WSUM_W-1:0]        weight_sum;
      logic                     is_total;
      logic                     bad_target;
   } rsp_word_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_TOT,
      ST_DIV,
      ST_EMIT
   } st_type;

   function automatic logic cls_in_range(input logic signed [15:0] c);
      return !c[15] && ({1'b0, c} < 17'(NUM_CLASSES));
   endfunction

   // clamp a 49-bit signed sum to 48 bits
   function automatic logic signed [LOSS_W-1:0] sat48(input logic signed [LOSS_W:0] s);
      logic signed [LOSS_W-1:0] r;
      if (s[LOSS_W] != s[LOSS_W-1]) begin
         r = s[LOSS_W] ? MIN48 : MAX48;
      end else begin
         r = s[LOSS_W-1:0];
      end
      return r;
   endfunction

   // magnitude of a 48-bit signed value, exact for the minimum
   function automatic logic [LOSS_W-1:0] abs48(input logic signed [LOSS_W-1:0] x);
      return x[LOSS_W-1] ? (~x + 48'd1) : x;
   endfunction

endpackage

### hdl/wnll_div.sv
// restoring divider, one quotient bit per cycle
`include "weighted_nll_loss_accumulator_macros.svh"

module wnll_div
   import wnll_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] dividend,
   input  logic [DIV_DEN_W-1:0] divisor,
   output div_status_type       status,
   output logic [DIV_NUM_W-1:0] quotient
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_DEN_W-1:0] rem_ff;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_NUM_W-1:0] quo_ff;

   logic [DIV_DEN_W:0]   trial;
   logic [DIV_DEN_W:0]   diff;
   logic                 fits;

   assign trial = {rem_ff, quo_ff[DIV_NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = !diff[DIV_DEN_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_W'(DIV_NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         den_ff <= divisor;
         quo_ff <= dividend;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
         quo_ff <= {quo_ff[DIV_NUM_W-2:0], fits};
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

   `WNLL_ASSERT_NXT(a_done_pulse, clock, reset, done_ff, !done_ff, "done held longer than a cycle")
   `WNLL_ASSERT_IMP(a_start_idle, clock, reset, start, !busy_ff, "divider started while busy")
   `WNLL_ASSERT_IMP(a_busy_count, clock, reset, busy_ff, cnt_ff != '0, "busy with no steps left")

endmodule

### hdl/weighted_nll_loss_accumulator.sv
// top level of the weighted nll loss accumulator
//
//  port group  | direction | handshake         | word
//  ------------+-----------+-------------------+---------------------------------
//  req_        | in        | req_valid/stall   | kind, class_index, value, last
//  rsp_        | out       | rsp_valid/stall   | loss, weight_sum, is_total, bad
//  csr_        | in        | csr_we            | index 0..3, 16-bit data
//
//  a weight write is taken while idle; a pixel passes memory read, multiply and
//  accumulate, then a per-pixel result goes to emit, a total through a total step first
//  a total with averaging adds the divider, one quotient bit a cycle
//  reset is synchronous and returns the registers and accumulators to defaults;
//  the weight memory is not cleared
//  a finished word waits in the output register, so the next word is accepted
//  while rsp_stall is high; only a second result then waits for the register
`include "weighted_nll_loss_accumulator_macros.svh"

module weighted_nll_loss_accumulator
   import wnll_pkg::*;
(
   input  logic         clock,
   input  logic         reset,

   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,

   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,

   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wdata
);

   // configuration registers
   logic signed [15:0] ignore_class_ff;
   logic               size_average_ff;
   logic               reduce_mode_ff;
   logic               use_weights_ff;

   // fsm
   st_type state_ff;
   st_type state_in;

   // control decoded from the state
   logic req_take;
   logic mem_we;
   logic div_start;
   logic rsp_load;

   // class weight memory
   logic signed [WT_W-1:0] wt_mem [NUM_CLASSES];
   logic signed [WT_W-1:0] rd_ff;

   // item and pipeline registers
   req_word_type             item_ff;
   logic signed [2*WT_W-1:0] prod_ff;
   logic signed [WT_W-1:0]   w_ff;
   logic                     ign_ff;
   logic                     bad_ff;

   // accumulators
   logic signed [LOSS_W-1:0] loss_acc_ff;
   logic signed [LOSS_W-1:0] loss_acc_in;
   logic signed [LOSS_W-1:0] weight_acc_ff;
   logic signed [LOSS_W-1:0] weight_acc_in;
   logic                     error_seen_ff;
   logic                     error_seen_in;
   logic                     neg_ff;

   // result staging and output register
   rsp_word_type res_ff;
   rsp_word_type rsp_word_ff;
   logic         rsp_valid_ff;

   // datapath helpers
   logic                     item_ign;
   logic                     item_bad;
   logic signed [WT_W-1:0]   item_w;
   logic signed [LOSS_W-1:0] prod_q;
   logic signed [LOSS_W-1:0] pix_loss;
   logic                     counted;
   logic signed [LOSS_W:0]   loss_sum;
   logic signed [LOSS_W:0]   w_sum;
   logic                     do_avg;
   logic [WSUM_W-1:0]        wsum_out;

   // divider
   div_status_type        div_sts;
   logic [DIV_NUM_W-1:0]  div_quo;
   logic signed [LOSS_W-1:0] avg_loss;

   // ---------------------------------------------------------------- csr
   always_ff @(posedge clock) begin
      if (reset) begin
         ignore_class_ff <= -16'sd100;
         size_average_ff <= 1'b1;
         reduce_mode_ff  <= 1'b1;
         use_weights_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IGNORE_CLASS: ignore_class_ff <= csr_wdata;
            CSR_SIZE_AVERAGE: size_average_ff <= csr_wdata[0];
            CSR_REDUCE_MODE:  reduce_mode_ff  <= csr_wdata[0];
            CSR_USE_WEIGHTS:  use_weights_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- fsm
   assign req_take = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && req_word.kind == KIND_PIXEL) state_in = ST_MUL;
         end
         ST_MUL: state_in = ST_ACC;
         ST_ACC: begin
            if (!reduce_mode_ff) begin
               state_in = ST_EMIT;
            end else if (item_ff.last_pixel) begin
               state_in = ST_TOT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_TOT: state_in = do_avg ? ST_DIV : ST_EMIT;
         ST_DIV: begin
            if (div_sts.done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      mem_we    = 1'b0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            mem_we    = req_valid && req_word.kind == KIND_WEIGHT
                        && cls_in_range(req_word.class_index);
         end
         ST_TOT:  div_start = do_avg;
         ST_EMIT: rsp_load  = !rsp_valid_ff || !rsp_stall;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------------- weight memory
   // written by weight words, read for every accepted word; data lands in rd_ff
   always_ff @(posedge clock) begin
      if (mem_we) begin
         wt_mem[req_word.class_index[CLS_AW-1:0]] <= req_word.value;
      end
      if (req_take) begin
         rd_ff <= wt_mem[req_word.class_index[CLS_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= req_word;
      end
   end

   // ---------------------------------------------------------------- multiply stage
   assign item_ign = (item_ff.class_index == ignore_class_ff);
   assign item_bad = !item_ign && !cls_in_range(item_ff.class_index);
   assign item_w   = use_weights_ff ? rd_ff : ONE_Q16;

   always_ff @(posedge clock) begin
      if (state_ff == ST_MUL) begin
         prod_ff <= item_ff.value * item_w;
         w_ff    <= item_w;
         ign_ff  <= item_ign;
         bad_ff  <= item_bad;
      end
   end

   // ---------------------------------------------------------------- accumulate stage
   // arithmetic shift of the q32.32 product floors it to q32.16
   assign prod_q   = prod_ff[2*WT_W-1:16];
   assign counted  = !ign_ff && !bad_ff;
   assign pix_loss = counted ? (LOSS_W'(0) - prod_q) : '0;
   assign loss_sum = {loss_acc_ff[LOSS_W-1], loss_acc_ff} + {pix_loss[LOSS_W-1], pix_loss};
   assign w_sum    = {weight_acc_ff[LOSS_W-1], weight_acc_ff}
                     + {{(LOSS_W+1-WT_W){w_ff[WT_W-1]}}, w_ff};

   // totals use the already updated accumulators
   assign do_avg   = size_average_ff && (weight_acc_ff != '0);
   // negative weight sums show as zero
   assign wsum_out = weight_acc_ff[LOSS_W-1] ? '0 : weight_acc_ff[WSUM_W-1:0];

   always_comb begin
      loss_acc_in   = loss_acc_ff;
      weight_acc_in = weight_acc_ff;
      error_seen_in = error_seen_ff;
      if (state_ff == ST_ACC && reduce_mode_ff) begin
         if (bad_ff) error_seen_in = 1'b1;
         if (counted) begin
            loss_acc_in   = sat48(loss_sum);
            weight_acc_in = sat48(w_sum);
         end
      end else if (state_ff == ST_TOT) begin
         // total taken: start the next batch from zero
         loss_acc_in   = '0;
         weight_acc_in = '0;
         error_seen_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loss_acc_ff   <= '0;
         weight_acc_ff <= '0;
         error_seen_ff <= 1'b0;
      end else begin
         loss_acc_ff   <= loss_acc_in;
         weight_acc_ff <= weight_acc_in;
         error_seen_ff <= error_seen_in;
      end
   end

   // ---------------------------------------------------------------- averaging divide
   wnll_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({abs48(loss_acc_ff), 16'd0}),
      .divisor  (abs48(weight_acc_ff)),
      .status   (div_sts),
      .quotient (div_quo)
   );

   // signed quotient, clamped to 48 bits; a negative result may reach 2^47
   always_comb begin
      if (neg_ff) begin
         if (div_quo > {{(DIV_NUM_W-LOSS_W){1'b0}}, MIN48}) begin
            avg_loss = MIN48;
         end else begin
            avg_loss = LOSS_W'(0) - div_quo[LOSS_W-1:0];
         end
      end else begin
         if (div_quo > DIV_NUM_W'(MAX48)) begin
            avg_loss = MAX48;
         end else begin
            avg_loss = div_quo[LOSS_W-1:0];
         end
      end
   end

   // ---------------------------------------------------------------- result staging
   always_ff @(posedge clock) begin
      if (state_ff == ST_ACC && !reduce_mode_ff) begin
         res_ff.loss       <= pix_loss;
         res_ff.weight_sum <= '0;
         res_ff.is_total   <= 1'b0;
         res_ff.bad_target <= bad_ff;
      end else if (state_ff == ST_TOT) begin
         res_ff.loss       <= loss_acc_ff;
         res_ff.weight_sum <= wsum_out;
         res_ff.is_total   <= 1'b1;
         res_ff.bad_target <= error_seen_ff;
         neg_ff            <= loss_acc_ff[LOSS_W-1] ^ weight_acc_ff[LOSS_W-1];
      end else if (state_ff == ST_DIV && div_sts.done) begin
         res_ff.loss <= avg_loss;
      end
   end

   // ---------------------------------------------------------------- output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_word_ff <= res_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // ---------------------------------------------------------------- checks
   `WNLL_ASSERT_IMP(a_total_clears, clock, reset,
      state_ff == ST_EMIT && res_ff.is_total,
      loss_acc_ff == '0 && weight_acc_ff == '0 && !error_seen_ff,
      "accumulators not cleared after total")
   `WNLL_ASSERT_IMP(a_pixel_wsum, clock, reset,
      rsp_valid_ff && !rsp_word_ff.is_total, rsp_word_ff.weight_sum == '0,
      "per-pixel word with nonzero weight sum")
   `WNLL_ASSERT_IMP(a_div_wait, clock, reset,
      state_ff == ST_DIV, div_sts.busy || div_sts.done,
      "waiting on an idle divider")

endmodule

### tb/tb_weighted_nll_loss_accumulator.sv
// self-checking testbench for the weighted nll loss accumulator
module tb_weighted_nll_loss_accumulator
   import wnll_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_REGS     = 4;
   localparam int DRAIN_CYCLES = 100;
   localparam int NUM_PHASES   = 9;
   localparam int PHASE_WORDS  = 50;

   // ---------------------------------------------------------------------
   // loss scoreboard: tracks the weight table, accumulators and registers,
   // and holds the result words still owed by the block
   // ---------------------------------------------------------------------
   class loss_scoreboard;
      localparam longint LOSS_TOP    = 64'sh0000_7FFF_FFFF_FFFF;
      localparam longint LOSS_BOTTOM = -LOSS_TOP - 1;
      localparam logic [63:0] QUO_TOP = 64'h0000_7FFF_FFFF_FFFF;

      logic signed [WT_W-1:0] class_weight [NUM_CLASSES];
      longint                 loss_sum;
      longint                 weight_total;
      bit                     bad_seen;
      logic signed [15:0]     skip_class;
      bit                     avg_on;
      bit                     reduce_on;
      bit                     weights_on;
      rsp_word_type           expected_q [$];
      int                     mismatches;

      function new();
         foreach (class_weight[i]) class_weight[i] = '0;
         loss_sum     = 0;
         weight_total = 0;
         bad_seen     = 1'b0;
         skip_class   = -16'sd100;
         avg_on       = 1'b1;
         reduce_on    = 1'b1;
         weights_on   = 1'b0;
         mismatches   = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [15:0] data);
         case (idx)
            CSR_IGNORE_CLASS: skip_class = data;
            CSR_SIZE_AVERAGE: avg_on     = data[0];
            CSR_REDUCE_MODE:  reduce_on  = data[0];
            CSR_USE_WEIGHTS:  weights_on = data[0];
            default: ;
         endcase
      endfunction

      function longint clamp48(longint x);
         if (x > LOSS_TOP) return LOSS_TOP;
         if (x < LOSS_BOTTOM) return LOSS_BOTTOM;
         return x;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // one accepted word in, zero or one expected result word out
      function void note_word(req_word_type w);
         rsp_word_type       e;
         logic signed [15:0] cls;
         logic signed [31:0] val;
         longint             wt;
         longint             loss;
         longint             total;
         logic [63:0]        num_mag;
         logic [63:0]        den_mag;
         logic [63:0]        quo;
         bit                 skipped;
         bit                 bad;

         cls = w.class_index;
         val = w.value;
         if (w.kind == KIND_WEIGHT) begin
            if (cls >= 0 && cls < NUM_CLASSES) class_weight[cls[CLS_AW-1:0]] = val;
            return;
         end

         skipped = (cls == skip_class);
         bad     = !skipped && (cls < 0 || cls >= NUM_CLASSES);
         wt      = ONE_Q16;
         loss    = 0;
         if (!skipped && !bad) begin
            if (weights_on) wt = class_weight[cls[CLS_AW-1:0]];
            // exact product, floored to q32.16, then negated
            loss = -((longint'(val) * wt) >>> 16);
         end

         if (!reduce_on) begin
            e.loss       = loss[LOSS_W-1:0];
            e.weight_sum = '0;
            e.is_total   = 1'b0;
            e.bad_target = bad;
            expected_q.push_back(e);
            return;
         end

         if (bad) bad_seen = 1'b1;
         if (!skipped && !bad) begin
            loss_sum     = clamp48(loss_sum + loss);
            weight_total = clamp48(weight_total + wt);
         end
         if (!w.last_pixel) return;

         total = loss_sum;
         if (avg_on && weight_total != 0) begin
            // divide on magnitudes, truncate toward zero, clamp to 48 bits
            num_mag = (loss_sum < 0) ? -loss_sum : loss_sum;
            num_mag = num_mag << 16;
            den_mag = (weight_total < 0) ? -weight_total : weight_total;
            quo     = num_mag / den_mag;
            if ((loss_sum < 0) != (weight_total < 0)) begin
               total = (quo > QUO_TOP + 64'd1) ? LOSS_BOTTOM : -longint'(quo);
            end else begin
               total = (quo > QUO_TOP) ? LOSS_TOP : longint'(quo);
            end
         end
         e.loss       = total[LOSS_W-1:0];
         e.weight_sum = (weight_total < 0) ? '0 : weight_total[WSUM_W-1:0];
         e.is_total   = 1'b1;
         e.bad_target = bad_seen;
         expected_q.push_back(e);
         loss_sum     = 0;
         weight_total = 0;
         bad_seen     = 1'b0;
      endfunction

      function void check_word(rsp_word_type got);
         rsp_word_type e;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected result word: loss %0d weight_sum %0d total %0b bad %0b",
                        $time, got.loss, got.weight_sum, got.is_total, got.bad_target);
            return;
         end
         e = expected_q.pop_front();
         if (got.loss !== e.loss || got.weight_sum !== e.weight_sum ||
             got.is_total !== e.is_total || got.bad_target !== e.bad_target) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: result mismatch", $time);
               $display("   expected loss %0d weight_sum %0d total %0b bad %0b",
                        e.loss, e.weight_sum, e.is_total, e.bad_target);
               $display("   actual   loss %0d weight_sum %0d total %0b bad %0b",
                        got.loss, got.weight_sum, got.is_total, got.bad_target);
            end
         end
      endfunction
   endclass

   // ---------------------------------------------------------------------
   // block under test and its ports
   // ---------------------------------------------------------------------
   logic         clock;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_we    = 1'b0;
   logic [1:0]   csr_index = '0;
   logic [15:0]  csr_wdata = '0;

   weighted_nll_loss_accumulator u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   loss_scoreboard sb = new();

   // weight entries written so far, so that no pixel reads an unwritten one
   bit written_class [NUM_CLASSES];

   // idle rates in percent for each side
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver stalls at random, independent of anything else
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // every accepted result word goes to the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_word(rsp_word);
   end

   // hard stop in case the block hangs
   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // ---------------------------------------------------------------------
   // driving tasks
   // ---------------------------------------------------------------------

   // write all four registers while the block is idle; only bit 0 of the
   // one-bit registers matters, the upper data bits are random noise
   task automatic set_config(input logic [15:0] ign, input bit avg, input bit red,
                             input bit usew);
      logic [15:0] data [NUM_REGS];
      data[CSR_IGNORE_CLASS] = ign;
      data[CSR_SIZE_AVERAGE] = {15'($urandom), avg};
      data[CSR_REDUCE_MODE]  = {15'($urandom), red};
      data[CSR_USE_WEIGHTS]  = {15'($urandom), usew};
      for (int i = 0; i < NUM_REGS; i++) begin
         csr_we    <= 1'b1;
         csr_index <= 2'(i);
         csr_wdata <= data[i];
         @(posedge clock);
         sb.write_reg(2'(i), data[i]);
      end
      csr_we <= 1'b0;
   endtask

   // offer one word, with random idle cycles ahead of it, and hold it
   // until the block takes it
   task automatic send_word(input req_word_type w);
      logic signed [15:0] cls;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      sb.note_word(w);
      cls = w.class_index;
      if (w.kind == KIND_WEIGHT && cls >= 0 && cls < NUM_CLASSES)
         written_class[cls[CLS_AW-1:0]] = 1'b1;
   endtask

   // sender pauses until nothing is owed, then the block gets time to
   // finish work that gives no result
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic req_word_type make_word(input logic kind, input logic signed [15:0] cls,
                                              input logic signed [31:0] val,
                                              input logic last);
      req_word_type w;
      w.kind        = kind;
      w.class_index = cls;
      w.value       = val;
      w.last_pixel  = last;
      return w;
   endfunction

   // mostly in-range pixels forming batches, some weight writes, skipped
   // and out-of-range targets and raw noise
   function automatic req_word_type random_word();
      req_word_type       w;
      logic signed [15:0] cls;
      int                 pick;

      w.kind = ($urandom_range(19) < 3) ? KIND_WEIGHT : KIND_PIXEL;
      pick = $urandom_range(19);
      if (pick < 14) begin
         cls = 16'($urandom_range(NUM_CLASSES - 1));
      end else if (pick < 16) begin
         cls = sb.skip_class;
      end else if (pick < 18) begin
         cls = $urandom_range(1) ? -16'sd1 - 16'($urandom_range(32767))
                                 : 16'($urandom_range(32767, NUM_CLASSES));
      end else begin
         cls = 16'($urandom);
      end
      w.class_index = cls;

      case ($urandom_range(9))
         0:       w.value = 32'sh8000_0000;
         1:       w.value = 32'sh7FFF_FFFF;
         2:       w.value = ONE_Q16;
         3, 4:    w.value = 32'($urandom_range(1 << 20)) - 32'(1 << 19);
         default: w.value = $urandom;
      endcase

      // short batches in reduce mode, last flag is noise otherwise
      w.last_pixel = sb.reduce_on ? ($urandom_range(5) == 0) : 1'($urandom);

      // a pixel that would read an unwritten weight becomes its write
      if (w.kind == KIND_PIXEL && sb.weights_on && cls >= 0 && cls < NUM_CLASSES &&
          cls != sb.skip_class && !written_class[cls[CLS_AW-1:0]])
         w.kind = KIND_WEIGHT;
      return w;
   endfunction

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 11;
      recv_idle_pct = 56;

      // directed: weighted reduce with averaging
      set_config(-16'sd100, 1'b1, 1'b1, 1'b1);
      send_word(make_word(KIND_WEIGHT, 16'sd0, ONE_Q16, 1'b0));
      send_word(make_word(KIND_WEIGHT, 16'sd255, 32'sh8000_0000, 1'b0));
      send_word(make_word(KIND_WEIGHT, 16'sd1, 32'sh7FFF_FFFF, 1'b0));
      send_word(make_word(KIND_WEIGHT, 16'sd2, 32'sh8000_0001, 1'b0));
      send_word(make_word(KIND_WEIGHT, 16'sd3, 32'sd1, 1'b0));
      // weight writes outside the table are dropped
      send_word(make_word(KIND_WEIGHT, -16'sd1, 32'sd5, 1'b1));
      send_word(make_word(KIND_WEIGHT, 16'sd256, 32'sd5, 1'b1));
      send_word(make_word(KIND_WEIGHT, 16'sh8000, 32'sh7FFF_FFFF, 1'b0));
      // smallest negative score, averaged total of one
      send_word(make_word(KIND_PIXEL, 16'sd0, 32'shFFFF_FFFF, 1'b1));
      // extreme products drive the loss sum into saturation
      send_word(make_word(KIND_PIXEL, 16'sd255, 32'sh8000_0000, 1'b0));
      send_word(make_word(KIND_PIXEL, 16'sd255, 32'sh8000_0000, 1'b0));
      send_word(make_word(KIND_PIXEL, 16'sd255, 32'sh8000_0000, 1'b0));
      // skipped pixel, then a bad target closes the batch
      send_word(make_word(KIND_PIXEL, -16'sd100, 32'sh7FFF_FFFF, 1'b0));
      send_word(make_word(KIND_PIXEL, 16'sd300, 32'sd77, 1'b1));
      // opposite weights cancel, a tiny weight makes the quotient overflow
      send_word(make_word(KIND_PIXEL, 16'sd1, 32'sh7FFF_FFFF, 1'b0));
      send_word(make_word(KIND_PIXEL, 16'sd2, 32'sh8000_0001, 1'b0));
      send_word(make_word(KIND_PIXEL, 16'sd3, 32'sd0, 1'b1));
      // empty batch: zero weight sum, total left undivided
      send_word(make_word(KIND_PIXEL, -16'sd100, 32'sd0, 1'b1));
      send_word(make_word(KIND_PIXEL, 16'sh7FFF, 32'sd9, 1'b1));
      drain();

      // directed: per-pixel, unit weight, top class value skipped
      set_config(16'sh7FFF, 1'b0, 1'b0, 1'b0);
      send_word(make_word(KIND_PIXEL, 16'sh7FFF, 32'sd5, 1'b1));
      send_word(make_word(KIND_PIXEL, 16'sh8000, 32'sd5, 1'b0));
      send_word(make_word(KIND_PIXEL, 16'sd0, 32'sh8000_0000, 1'b1));
      send_word(make_word(KIND_PIXEL, 16'sd255, 32'sh7FFF_FFFF, 1'b0));
      drain();

      // directed: reduce without averaging
      set_config(-16'sd100, 1'b0, 1'b1, 1'b0);
      send_word(make_word(KIND_PIXEL, 16'sd4, 32'sh0003_0000, 1'b0));
      send_word(make_word(KIND_PIXEL, 16'sd5, 32'shFFFF_0000, 1'b1));
      drain();

      // random phases over several settings and idle patterns
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0:       set_config(-16'sd100, 1'b1, 1'b1, 1'b1);
            1:       set_config(16'sd0, 1'b0, 1'b0, 1'b1);
            2:       set_config(16'sd255, 1'b1, 1'b1, 1'b0);
            3:       set_config(16'sh8000, 1'b0, 1'b1, 1'b1);
            4:       set_config(16'sh7FFF, 1'b1, 1'b0, 1'b0);
            5:       set_config(16'($urandom), 1'b0, 1'b1, 1'b0);
            6:       set_config(16'sd7, 1'b1, 1'b1, 1'b1);
            7:       set_config(16'($urandom_range(NUM_CLASSES - 1)), 1'b1, 1'b0, 1'b1);
            default: set_config(-16'sd100, 1'b0, 1'b1, 1'b1);
         endcase
         // sender light / receiver heavy, then swapped, then no idling
         if (phase < 3) begin
            send_idle_pct = 11;
            recv_idle_pct = 56;
         end else if (phase < 6) begin
            send_idle_pct = 56;
            recv_idle_pct = 11;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         repeat (PHASE_WORDS) send_word(random_word());
         drain();
      end

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+hdl
hdl/wnll_pkg.sv
hdl/wnll_div.sv
hdl/weighted_nll_loss_accumulator.sv
tb/tb_weighted_nll_loss_accumulator.sv
